// ----- rtl/core/krs_pkg.sv -----
package krs_pkg;

  localparam int KRS_DEPTH = 16;

  typedef enum logic [2:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_READ   = 3'd2,
    FN_SEARCH = 3'd3,
    FN_UPDATE = 3'd4,
    FN_DELETE = 3'd5
  } krs_func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } krs_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } krs_state_t;

  typedef struct packed {
    logic [15:0]        id;
    logic [31:0]        name_tag;
    logic signed [31:0] price;
  } krs_rec_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [15:0]        item_id;
    logic [31:0]        item_name_tag;
    logic signed [31:0] item_price;
    logic [3:0]         position;
  } krs_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        found_id;
    logic [31:0]        found_name_tag;
    logic signed [31:0] found_price;
    logic [4:0]         entry_count;
  } krs_out_t;

endpackage

// ----- rtl/core/keyed_record_stack.sv -----
// Push, pop, read and error words go from acceptance to S_RESP, which loads out_valid
// when the output is not stalled. Search/update read and then compare each entry from
// the top (S_SCAN_RD, S_SCAN_CMP) before S_RESP; delete, on a match, also moves each
// entry above it down to close the gap (S_SHIFT_RD, S_SHIFT_WR). Throughput: one word at
// a time; the scan and compaction loops over the record memory set the time. Synchronous
// active-low reset clears the count and control; record memory contents are not cleared.
module keyed_record_stack #(
  parameter int DEPTH = krs_pkg::KRS_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  krs_pkg::krs_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output krs_pkg::krs_out_t out_data
);
  import krs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = CW + 4;

  krs_rec_t mem [DEPTH];

  krs_state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  krs_in_t     req_r;
  krs_status_t res_status_r, res_status_nxt;
  logic        res_use_rd_r, res_use_rd_nxt;
  krs_rec_t    rdata_r;
  logic        out_valid_r;
  krs_out_t    out_data_r;

  logic          in_accept;
  logic          out_load;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  krs_rec_t      wdata;
  logic          is_empty;
  logic          is_full;
  logic          more_to_shift;
  logic          id_match;
  krs_func_t     in_func;
  krs_func_t     req_func;

  assign in_stall      = (state_r != S_IDLE);
  assign in_accept     = in_valid && !in_stall;
  assign is_empty      = (count_r == '0);
  assign is_full       = (count_r >= CW'(DEPTH));
  assign more_to_shift = ((CW + 1)'(idx_r) + (CW + 1)'(1)) < (CW + 1)'(count_r);
  assign id_match      = (rdata_r.id == req_r.item_id);
  assign in_func       = krs_func_t'(in_data.func);
  assign req_func      = krs_func_t'(req_r.func);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if ((in_func == FN_SEARCH || in_func == FN_UPDATE || in_func == FN_DELETE) &&
              !is_empty) begin
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (id_match) begin
          state_nxt = (req_func == FN_DELETE) ? S_SHIFT_RD : S_RESP;
        end else if (idx_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_nxt = more_to_shift ? S_SHIFT_WR : S_RESP;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    rd_en          = 1'b0;
    raddr          = idx_r;
    we             = 1'b0;
    waddr          = idx_r;
    wdata          = rdata_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_use_rd_nxt = res_use_rd_r;
    out_load       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_status_nxt = ST_OK;
          res_use_rd_nxt = 1'b0;
          unique case (in_func)
            FN_PUSH: begin
              if (is_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = AW'(count_r);
                wdata     = '{id: in_data.item_id, name_tag: in_data.item_name_tag,
                              price: in_data.item_price};
                count_nxt = count_r + CW'(1);
              end
            end
            FN_POP: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en          = 1'b1;
                raddr          = AW'(count_r - CW'(1));
                count_nxt      = count_r - CW'(1);
                res_use_rd_nxt = 1'b1;
              end
            end
            FN_READ: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else if (PW'(in_data.position) >= PW'(count_r)) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                rd_en          = 1'b1;
                raddr          = AW'(PW'(count_r) - PW'(in_data.position) - PW'(1));
                res_use_rd_nxt = 1'b1;
              end
            end
            FN_SEARCH, FN_UPDATE, FN_DELETE: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                idx_nxt = AW'(count_r - CW'(1));
              end
            end
            default: res_status_nxt = ST_NOTFOUND;
          endcase
        end
      end
      S_SCAN_RD: begin
        rd_en = 1'b1;
        raddr = idx_r;
      end
      S_SCAN_CMP: begin
        if (id_match) begin
          if (req_func == FN_SEARCH) begin
            res_use_rd_nxt = 1'b1;
          end else if (req_func == FN_UPDATE) begin
            we    = 1'b1;
            waddr = idx_r;
            wdata = '{id: rdata_r.id, name_tag: req_r.item_name_tag,
                      price: req_r.item_price};
          end
        end else if (idx_r == '0) begin
          res_status_nxt = ST_NOTFOUND;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_SHIFT_RD: begin
        if (more_to_shift) begin
          rd_en = 1'b1;
          raddr = idx_r + AW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      S_SHIFT_WR: begin
        we      = 1'b1;
        waddr   = idx_r;
        wdata   = rdata_r;
        idx_nxt = idx_r + AW'(1);
      end
      S_RESP: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_use_rd_r <= res_use_rd_nxt;
    if (in_accept) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r.status         <= res_status_r;
      out_data_r.found_id       <= res_use_rd_r ? rdata_r.id : '0;
      out_data_r.found_name_tag <= res_use_rd_r ? rdata_r.name_tag : '0;
      out_data_r.found_price    <= res_use_rd_r ? rdata_r.price : '0;
      out_data_r.entry_count    <= 5'(count_r);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("record count above depth");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CMP) |-> $past(rd_en))
    else $error("compare without a preceding memory read");

  a_shift_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_WR) |-> ($past(rd_en) && $past(state_r) == S_SHIFT_RD))
    else $error("compaction write without a preceding read");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("accepted word did not make the block busy");

endmodule
